// ----- hdl/vending_machine_controller_macros.svh -----
// Assertion macros shared by the vending controller modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef VENDING_MACHINE_CONTROLLER_MACROS_SVH
`define VENDING_MACHINE_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/vmc_pkg.sv -----
// Shared types, codes and constant tables of the vending controller.
// No dependencies; every other file of the block but the macro header refers to it by scoped names.
package vmc_pkg;

    // Default sizes and fixed field widths.
    localparam int SLOTS_DEF      = 4;
    localparam int STOCK_BITS_DEF = 8;
    localparam int STOCK_BITS_MAX = 16;
    localparam int PRICE_W        = 10;
    localparam int CHANGE_W       = 8;
    localparam int STOCK_OUT_W    = 8;
    localparam int SLOT_W         = 2;
    localparam int STATUS_W       = 3;
    localparam int MODE_W         = 2;
    localparam int ACT_W          = 3;
    localparam int COIN_W         = 2;
    localparam int CFG_ADDR_W     = 2;
    localparam int IN_DATA_W      = 8;
    localparam int OUT_DATA_W     = 40;

    // Operating modes.
    localparam logic [MODE_W-1:0] MODE_SELECT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PAYING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAINT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HALT   = 2'd3;

    // Action codes of an input item.
    localparam logic [ACT_W-1:0] ACT_CHOOSE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_COIN   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CANCEL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MAINT  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_QUIT   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_LIST   = 3'd5;

    // Coin kinds.
    localparam logic [COIN_W-1:0] COIN_100  = 2'd0;
    localparam logic [COIN_W-1:0] COIN_200  = 2'd1;
    localparam logic [COIN_W-1:0] COIN_50   = 2'd2;
    localparam logic [COIN_W-1:0] COIN_NONE = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ACCEPT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SOLDOUT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DISPENSE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CANCEL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORE   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LIST     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_HALT     = 3'd6;

    // One result item as it leaves the sequencer.
    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [MODE_W-1:0]      mode_now;
        logic [SLOT_W-1:0]      slot_out;
        logic [PRICE_W-1:0]     amount_due;
        logic [CHANGE_W-1:0]    change_out;
        logic [STOCK_OUT_W-1:0] stock_out;
        logic [PRICE_W-1:0]     price_out;
        logic                   last_result;
    } res_t;

    // Value in cents of each coin kind.
    function automatic logic [PRICE_W-1:0] coin_value(input logic [COIN_W-1:0] kind);
        logic [PRICE_W-1:0] val;
        case (kind)
            COIN_100: val = 10'd100;
            COIN_200: val = 10'd200;
            COIN_50:  val = 10'd50;
            default:  val = 10'd0;
        endcase
        return val;
    endfunction

    // Price of each slot after reset.
    function automatic logic [PRICE_W-1:0] price_reset(input int idx);
        logic [PRICE_W-1:0] val;
        case (idx)
            0:       val = 10'd250;
            1:       val = 10'd200;
            2:       val = 10'd250;
            default: val = 10'd100;
        endcase
        return val;
    endfunction

    // Stock of each slot after reset.
    function automatic logic [STOCK_BITS_MAX-1:0] stock_reset(input int idx);
        logic [STOCK_BITS_MAX-1:0] val;
        case (idx)
            0:       val = 16'd4;
            1:       val = 16'd1;
            2:       val = 16'd0;
            default: val = 16'd10;
        endcase
        return val;
    endfunction

endpackage

// ----- hdl/vmc_alu.sv -----
// Shared subtract and compare unit of the vending controller.
// Depends on vmc_pkg for its default width; the sequencer in vmc_ctrl drives its operands.
module vmc_alu #(
    parameter int W = vmc_pkg::PRICE_W
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         ge
);

    logic borrow;

    // One subtraction gives both the difference and the a >= b flag.
    assign {borrow, diff} = {1'b0, a} - {1'b0, b};
    assign ge = ~borrow;

endmodule

// ----- hdl/vmc_ctrl.sv -----
// Sequencer of the vending controller: mode, amount due, stock counts and
// the steps that drive the shared vmc_alu. Uses vmc_pkg and the macro header.
`include "vending_machine_controller_macros.svh"

module vmc_ctrl #(
    parameter int SLOTS      = vmc_pkg::SLOTS_DEF,
    parameter int STOCK_BITS = vmc_pkg::STOCK_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [vmc_pkg::ACT_W-1:0]              in_action,
    input  logic [vmc_pkg::SLOT_W-1:0]             in_slot,
    input  logic [vmc_pkg::COIN_W-1:0]             in_coin,
    input  logic [SLOTS-1:0][vmc_pkg::PRICE_W-1:0] price,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output vmc_pkg::res_t                          res
);

    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ALU_W = (STOCK_BITS > vmc_pkg::PRICE_W) ? STOCK_BITS : vmc_pkg::PRICE_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DEC  = 9'b000000010,
        S_STK  = 9'b000000100,
        S_PRC  = 9'b000001000,
        S_COIN = 9'b000010000,
        S_SUB  = 9'b000100000,
        S_DSP  = 9'b001000000,
        S_LIST = 9'b010000000,
        S_EMIT = 9'b100000000
    } state_t;

    state_t                             state_reg, state_next;
    logic [vmc_pkg::MODE_W-1:0]         mode_reg, mode_next;
    logic [vmc_pkg::PRICE_W-1:0]        due_reg, due_next;
    logic [vmc_pkg::SLOT_W-1:0]         chosen_reg, chosen_next;
    logic [STOCK_BITS-1:0]              stock_reg [SLOTS];
    logic [STOCK_BITS-1:0]              stock_wr_data;
    logic                               stock_we;
    logic [IW-1:0]                      idx_reg, idx_next;

    logic [vmc_pkg::ACT_W-1:0]          act_reg;
    logic [vmc_pkg::SLOT_W-1:0]         choice_reg;
    logic [vmc_pkg::COIN_W-1:0]         coin_reg;

    logic [vmc_pkg::STATUS_W-1:0]       r_status_reg, r_status_next;
    logic [vmc_pkg::SLOT_W-1:0]         r_slot_reg, r_slot_next;
    logic [vmc_pkg::CHANGE_W-1:0]       r_change_reg, r_change_next;
    logic [vmc_pkg::STOCK_OUT_W-1:0]    r_stock_reg, r_stock_next;
    logic [vmc_pkg::PRICE_W-1:0]        r_price_reg, r_price_next;
    logic                               r_last_reg, r_last_next;

    logic [IW-1:0]                      rd_idx;
    logic [STOCK_BITS-1:0]              rd_stock;
    logic [vmc_pkg::PRICE_W-1:0]        rd_price;
    logic [ALU_W-1:0]                   alu_a, alu_b, alu_diff;
    logic                               alu_ge;
    logic                               choice_ok;
    logic                               list_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign choice_ok = ({1'b0, choice_reg} < 3'(SLOTS));
    assign list_last = (idx_reg == IW'(SLOTS - 1));

    // Single read port on the stock and price tables.
    always_comb
    begin
        rd_idx = idx_reg;
        if (state_reg == S_STK)
        begin
            rd_idx = IW'(choice_reg);
        end
        else if (state_reg == S_PRC || state_reg == S_DSP)
        begin
            rd_idx = IW'(chosen_reg);
        end
    end

    assign rd_stock = stock_reg[rd_idx];
    assign rd_price = price[rd_idx];

    // The shared subtract and compare unit.
    vmc_alu #(
        .W (ALU_W)
    ) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    // Step sequencer.
    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        due_next      = due_reg;
        chosen_next   = chosen_reg;
        idx_next      = idx_reg;
        stock_we      = 1'b0;
        stock_wr_data = alu_diff[STOCK_BITS-1:0];
        r_status_next = r_status_reg;
        r_slot_next   = r_slot_reg;
        r_change_next = r_change_reg;
        r_stock_next  = r_stock_reg;
        r_price_next  = r_price_reg;
        r_last_next   = r_last_reg;
        alu_a         = ALU_W'(rd_stock);
        alu_b         = ALU_W'(1);
        res_valid     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DEC;
                end
            end

            S_DEC:
            begin
                // Plain single result unless a branch below says otherwise.
                r_status_next = vmc_pkg::ST_IGNORE;
                r_slot_next   = '0;
                r_change_next = '0;
                r_stock_next  = '0;
                r_price_next  = '0;
                r_last_next   = 1'b1;
                state_next    = S_EMIT;
                if (mode_reg == vmc_pkg::MODE_HALT)
                begin
                    r_status_next = vmc_pkg::ST_HALT;
                end
                else if (mode_reg == vmc_pkg::MODE_SELECT)
                begin
                    if (act_reg == vmc_pkg::ACT_CHOOSE && choice_ok)
                    begin
                        state_next = S_STK;
                    end
                    else if (act_reg == vmc_pkg::ACT_MAINT)
                    begin
                        mode_next     = vmc_pkg::MODE_MAINT;
                        r_status_next = vmc_pkg::ST_ACCEPT;
                    end
                    else if (act_reg == vmc_pkg::ACT_QUIT)
                    begin
                        mode_next     = vmc_pkg::MODE_HALT;
                        r_status_next = vmc_pkg::ST_HALT;
                    end
                end
                else if (mode_reg == vmc_pkg::MODE_PAYING)
                begin
                    if (act_reg == vmc_pkg::ACT_COIN && coin_reg != vmc_pkg::COIN_NONE)
                    begin
                        state_next = S_COIN;
                    end
                    else if (act_reg == vmc_pkg::ACT_CANCEL)
                    begin
                        mode_next     = vmc_pkg::MODE_SELECT;
                        due_next      = '0;
                        r_status_next = vmc_pkg::ST_CANCEL;
                    end
                end
                else
                begin
                    if (act_reg == vmc_pkg::ACT_LIST)
                    begin
                        idx_next   = '0;
                        state_next = S_LIST;
                    end
                    else if (act_reg == vmc_pkg::ACT_CANCEL)
                    begin
                        mode_next     = vmc_pkg::MODE_SELECT;
                        r_status_next = vmc_pkg::ST_CANCEL;
                    end
                end
            end

            S_STK:
            begin
                // Stock of the chosen slot compared against one.
                if (!alu_ge)
                begin
                    r_status_next = vmc_pkg::ST_SOLDOUT;
                    r_slot_next   = choice_reg;
                    state_next    = S_EMIT;
                end
                else
                begin
                    chosen_next = choice_reg;
                    state_next  = S_PRC;
                end
            end

            S_PRC:
            begin
                // Zero >= price means a free drink.
                alu_a = '0;
                alu_b = ALU_W'(rd_price);
                if (alu_ge)
                begin
                    r_change_next = '0;
                    state_next    = S_DSP;
                end
                else
                begin
                    due_next      = rd_price;
                    mode_next     = vmc_pkg::MODE_PAYING;
                    r_status_next = vmc_pkg::ST_ACCEPT;
                    r_slot_next   = chosen_reg;
                    state_next    = S_EMIT;
                end
            end

            S_COIN:
            begin
                // Does the coin cover what is still due?
                alu_a = ALU_W'(vmc_pkg::coin_value(coin_reg));
                alu_b = ALU_W'(due_reg);
                if (alu_ge)
                begin
                    r_change_next = alu_diff[vmc_pkg::CHANGE_W-1:0];
                    state_next    = S_DSP;
                end
                else
                begin
                    state_next = S_SUB;
                end
            end

            S_SUB:
            begin
                alu_a         = ALU_W'(due_reg);
                alu_b         = ALU_W'(vmc_pkg::coin_value(coin_reg));
                due_next      = alu_diff[vmc_pkg::PRICE_W-1:0];
                r_status_next = vmc_pkg::ST_ACCEPT;
                r_slot_next   = chosen_reg;
                state_next    = S_EMIT;
            end

            S_DSP:
            begin
                // Decrement the stock and return to select mode.
                stock_we      = 1'b1;
                due_next      = '0;
                mode_next     = vmc_pkg::MODE_SELECT;
                r_status_next = vmc_pkg::ST_DISPENSE;
                r_slot_next   = chosen_reg;
                r_stock_next  = vmc_pkg::STOCK_OUT_W'(alu_diff[STOCK_BITS-1:0]);
                r_price_next  = '0;
                r_last_next   = 1'b1;
                state_next    = S_EMIT;
            end

            S_LIST:
            begin
                r_status_next = vmc_pkg::ST_LIST;
                r_slot_next   = vmc_pkg::SLOT_W'(idx_reg);
                r_stock_next  = vmc_pkg::STOCK_OUT_W'(rd_stock);
                r_price_next  = rd_price;
                r_last_next   = list_last;
                state_next    = S_EMIT;
            end

            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    if (r_status_reg == vmc_pkg::ST_LIST && !r_last_reg)
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_LIST;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and stock counts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= vmc_pkg::MODE_SELECT;
            due_reg    <= '0;
            chosen_reg <= '0;
            idx_reg    <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                stock_reg[i] <= STOCK_BITS'(vmc_pkg::stock_reset(i));
            end
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            due_reg    <= due_next;
            chosen_reg <= chosen_next;
            idx_reg    <= idx_next;
            if (stock_we)
            begin
                stock_reg[rd_idx] <= stock_wr_data;
            end
        end
    end

    // Latched input item and pending result fields.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg    <= in_action;
            choice_reg <= in_slot;
            coin_reg   <= in_coin;
        end
        r_status_reg <= r_status_next;
        r_slot_reg   <= r_slot_next;
        r_change_reg <= r_change_next;
        r_stock_reg  <= r_stock_next;
        r_price_reg  <= r_price_next;
        r_last_reg   <= r_last_next;
    end

    // Result item as seen by the output stage.
    always_comb
    begin
        res.status      = r_status_reg;
        res.mode_now    = mode_reg;
        res.slot_out    = r_slot_reg;
        res.amount_due  = (mode_reg == vmc_pkg::MODE_PAYING) ? due_reg : '0;
        res.change_out  = r_change_reg;
        res.stock_out   = r_stock_reg;
        res.price_out   = r_price_reg;
        res.last_result = r_last_reg;
    end

    // Checks on the sequencer.
    `VMC_ASSERT_NOW(a_ready_no_result, in_ready, !res_valid, "result offered while idle")
    `VMC_ASSERT_NEXT(a_halt_sticky, mode_reg == vmc_pkg::MODE_HALT, mode_reg == vmc_pkg::MODE_HALT, "left halted mode")
    `VMC_ASSERT_NOW(a_due_only_paying, mode_reg != vmc_pkg::MODE_PAYING, due_reg == '0, "amount due outside paying mode")

endmodule

// ----- hdl/vending_machine_controller.sv -----
// Channel  | Dir | Handshake                    | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser action, tdata slot and coin
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tuser status, tdata fields, tlast
// cfg      | in  | cfg_we                       | cfg_addr price slot, cfg_wdata price
//
// Each item, and each slot of a list, is worked by the sequencer, which steps one
// shared subtract and compare unit through the compares and updates.
// The output register lets the next item be accepted while a result waits.
// After reset the block is ready at once; prices and stock take their reset values.
// Top level of the vending controller; uses vmc_pkg, vmc_ctrl, vmc_alu and macros.
`include "vending_machine_controller_macros.svh"

module vending_machine_controller #(
    parameter int SLOTS      = vmc_pkg::SLOTS_DEF,
    parameter int STOCK_BITS = vmc_pkg::STOCK_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [vmc_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // slot_choice, coin_kind
    input  logic [vmc_pkg::ACT_W-1:0]           s_axis_tuser,  // action
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // mode_now, slot_out, amount_due, change_out, stock_out, price_out
    output logic [vmc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [vmc_pkg::STATUS_W-1:0]        m_axis_tuser,  // status
    output logic                                m_axis_tlast,
    input  logic                                cfg_we,
    input  logic [vmc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [vmc_pkg::PRICE_W-1:0]         cfg_wdata
);

    logic [SLOTS-1:0][vmc_pkg::PRICE_W-1:0] price_reg;
    logic                                   res_valid;
    logic                                   res_ready;
    vmc_pkg::res_t                          res;
    logic                                   out_valid_reg;
    vmc_pkg::res_t                          out_reg;

    // Price registers, written through the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                price_reg[i] <= vmc_pkg::price_reset(i);
            end
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (cfg_we && cfg_addr == vmc_pkg::CFG_ADDR_W'(i))
                begin
                    price_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    vmc_ctrl #(
        .SLOTS      (SLOTS),
        .STOCK_BITS (STOCK_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .in_slot   (s_axis_tdata[1:0]),
        .in_coin   (s_axis_tdata[3:2]),
        .price     (price_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: takes a result when empty or being drained.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    // Output item packing.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tlast  = out_reg.last_result;
    assign m_axis_tdata  = {out_reg.price_out, out_reg.stock_out, out_reg.change_out,
                            out_reg.amount_due, out_reg.slot_out, out_reg.mode_now};

    // Checks on the output stage.
    `VMC_ASSERT_NOW(a_dispense_in_select, out_valid_reg && out_reg.status == vmc_pkg::ST_DISPENSE, out_reg.mode_now == vmc_pkg::MODE_SELECT && out_reg.amount_due == '0, "dispense not back in select mode")
    `VMC_ASSERT_NOW(a_only_list_open, out_valid_reg && !out_reg.last_result, out_reg.status == vmc_pkg::ST_LIST, "non-final result outside a list")

endmodule
